// ===== hdl/seven_segment_frame_sender_defines.svh =====
`ifndef SEVEN_SEGMENT_FRAME_SENDER_DEFINES_SVH
`define SEVEN_SEGMENT_FRAME_SENDER_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define SSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checks that a condition is followed by another one in the next cycle.
`define SSD_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error(msg);

`endif

// ===== hdl/ssd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

    localparam int NUM_DIGITS  = 4;
    localparam int CODE_W      = 5;
    localparam int DIGIT_W     = 4;
    localparam int VALUE_W     = 14;
    localparam int REM1_W      = 10;
    localparam int REM2_W      = 7;
    localparam int IDX_W       = 3;
    localparam int GAP_W       = 3;
    localparam int GLYPH_COUNT = 22;
    localparam int COLON_DIGIT = 1;

    localparam int THOUSAND = 1000;
    localparam int HUNDRED  = 100;
    localparam int TEN      = 10;

    localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(9999);

    localparam logic [7:0] DATA_CMD      = 8'h40;
    localparam logic [7:0] ADDR_CMD      = 8'hC0;
    localparam logic [7:0] CTRL_BASE     = 8'h80;
    localparam logic [7:0] BLANK_PATTERN = 8'h00;

    localparam logic [7:0] GLYPH_TABLE [GLYPH_COUNT] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
        8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h76, 8'h38, 8'h54, 8'h73,
        8'h3E, 8'h00
    };

    // Position of each word inside a frame.
    localparam logic [IDX_W-1:0] IDX_DATA_CMD = 3'd0;
    localparam logic [IDX_W-1:0] IDX_ADDR_CMD = 3'd1;
    localparam logic [IDX_W-1:0] IDX_DIGIT0   = 3'd2;
    localparam logic [IDX_W-1:0] IDX_DIGIT1   = 3'd3;
    localparam logic [IDX_W-1:0] IDX_DIGIT2   = 3'd4;
    localparam logic [IDX_W-1:0] IDX_DIGIT3   = 3'd5;
    localparam logic [IDX_W-1:0] IDX_CONTROL  = 3'd6;

    // Gap counter load on each accepted request; busy stays high until it reaches zero.
    localparam logic [GAP_W-1:0] ACCEPT_GAP = 3'd6;

    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-1:0] ADDR_BRIGHTNESS = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_ENABLE     = 3'd4;

    localparam logic [1:0] COLON_ON_A = 2'd1;
    localparam logic [1:0] COLON_ON_B = 2'd2;

    typedef logic [NUM_DIGITS-1:0][CODE_W-1:0] t_code_set;
    typedef logic [NUM_DIGITS-1:0][7:0]        t_pattern_set;

    typedef struct packed {
        logic               opcode;
        t_code_set          code;
        logic [1:0]         colon_mode;
        logic [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic      valid;
        t_code_set code;
        logic      colon;
    } t_codes;

    typedef struct packed {
        logic       strobe;
        logic [7:0] bus_byte;
        logic       start_before;
        logic       stop_after;
        logic       last_of_frame;
    } t_word;

endpackage

`default_nettype wire

// ===== hdl/seven_segment_frame_sender.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Frame sender for a four-digit segment display driver.
// A request is accepted at a rising edge where start is high and busy is low.
// It carries four glyph codes and a colon mode, or a decimal value that is
// split into four digits and saturates at 9999.
// Each request yields seven words on o_bus_byte with their framing marks, one
// per cycle while o_strobe is high: data command, address command, four
// segment patterns and the display control byte, which ends the frame.
// After the accepting edge a request passes the split pipeline registers and
// then the merge output register before its first word is on the ports; the
// receiver cannot stall and takes each word in the cycle it is shown.
// Busy holds off new requests while a gap counter runs down, so each frame,
// sent one word per cycle, follows the previous frame with no overlap.
// Brightness and display enable sit in an APB register file at addresses 0
// and 4 and are read live when the control byte is formed.
// Synchronous reset clears the pipeline and sequencer, sets brightness to 1
// and enables the display.

module seven_segment_frame_sender (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_opcode,
    input  logic [4:0]                 i_glyph_first,
    input  logic [4:0]                 i_glyph_second,
    input  logic [4:0]                 i_glyph_third,
    input  logic [4:0]                 i_glyph_fourth,
    input  logic [1:0]                 i_colon_mode,
    input  logic [13:0]                i_number_value,
    output logic                       o_strobe,
    output logic [7:0]                 o_bus_byte,
    output logic                       o_start_before,
    output logic                       o_stop_after,
    output logic                       o_last_of_frame,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ssd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import ssd_pkg::*;

    logic [GAP_W-1:0] r_gap;
    logic [2:0]       r_brightness;
    logic             r_display_enable;

    logic             w_accept;
    logic             w_write;
    t_req             w_req;
    t_codes           w_codes;
    t_pattern_set     w_pats;
    t_word            w_word;

    assign busy     = (r_gap != '0);
    assign w_accept = start && !busy;
    assign pready   = 1'b1;
    assign w_write  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= '0;
        end else if (w_accept) begin
            r_gap <= ACCEPT_GAP;
        end else if (busy) begin
            r_gap <= r_gap - GAP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness     <= 3'd1;
            r_display_enable <= 1'b1;
        end else if (w_write) begin
            if (paddr == ADDR_BRIGHTNESS) begin
                r_brightness <= pwdata[2:0];
            end
            if (paddr == ADDR_ENABLE) begin
                r_display_enable <= pwdata[0];
            end
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_BRIGHTNESS: prdata = {29'd0, r_brightness};
            ADDR_ENABLE:     prdata = {31'd0, r_display_enable};
            default:         prdata = 32'd0;
        endcase
    end

    assign w_req.opcode     = i_opcode;
    assign w_req.code[0]    = i_glyph_first;
    assign w_req.code[1]    = i_glyph_second;
    assign w_req.code[2]    = i_glyph_third;
    assign w_req.code[3]    = i_glyph_fourth;
    assign w_req.colon_mode = i_colon_mode;
    assign w_req.value      = i_number_value;

    ssd_split u_split (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_req    (w_req),
        .o_codes  (w_codes)
    );

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_lane
        ssd_lane u_lane (
            .i_code    (w_codes.code[g]),
            .i_dot     ((g == COLON_DIGIT) && w_codes.colon),
            .o_pattern (w_pats[g])
        );
    end

    ssd_merge u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_codes.valid),
        .i_pats           (w_pats),
        .i_brightness     (r_brightness),
        .i_display_enable (r_display_enable),
        .o_word           (w_word)
    );

    assign o_strobe        = w_word.strobe;
    assign o_bus_byte      = w_word.bus_byte;
    assign o_start_before  = w_word.start_before;
    assign o_stop_after    = w_word.stop_after;
    assign o_last_of_frame = w_word.last_of_frame;

endmodule

`default_nettype wire

// ===== hdl/ssd_split.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssd_split (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  ssd_pkg::t_req  i_req,
    output ssd_pkg::t_codes o_codes
);
    import ssd_pkg::*;

    logic                r_v1, r_v2, r_v3, r_v4;
    logic                r_op1, r_op2, r_op3;
    t_code_set           r_code1, r_code2, r_code3;
    logic                r_colon1, r_colon2, r_colon3;
    logic [VALUE_W-1:0]  r_value1;
    logic [DIGIT_W-1:0]  r_thou2, r_thou3, r_hund3;
    logic [REM1_W-1:0]   r_rem2;
    logic [REM2_W-1:0]   r_rem3;
    t_code_set           r_code4;
    logic                r_colon4;

    logic [VALUE_W-1:0]  n_value;
    logic                n_colon;
    logic [DIGIT_W-1:0]  n_thou, n_hund, n_tens, n_ones;
    logic [REM1_W-1:0]   n_rem1;
    logic [REM2_W-1:0]   n_rem2;
    t_code_set           n_code;

    always_comb begin
        n_value = (i_req.value > VALUE_MAX) ? VALUE_MAX : i_req.value;
        n_colon = !i_req.opcode &&
                  ((i_req.colon_mode == COLON_ON_A) || (i_req.colon_mode == COLON_ON_B));
    end

    always_comb begin
        n_thou = '0;
        for (int k = 1; k <= 9; k++) begin
            if (r_value1 >= VALUE_W'(k * THOUSAND)) begin
                n_thou = DIGIT_W'(k);
            end
        end
        n_rem1 = REM1_W'(r_value1 - VALUE_W'(n_thou * THOUSAND));
    end

    always_comb begin
        n_hund = '0;
        for (int k = 1; k <= 9; k++) begin
            if (r_rem2 >= REM1_W'(k * HUNDRED)) begin
                n_hund = DIGIT_W'(k);
            end
        end
        n_rem2 = REM2_W'(r_rem2 - REM1_W'(n_hund * HUNDRED));
    end

    always_comb begin
        n_tens = '0;
        for (int k = 1; k <= 9; k++) begin
            if (r_rem3 >= REM2_W'(k * TEN)) begin
                n_tens = DIGIT_W'(k);
            end
        end
        n_ones = DIGIT_W'(r_rem3 - REM2_W'(n_tens * TEN));
        if (r_op3) begin
            n_code[0] = CODE_W'(r_thou3);
            n_code[1] = CODE_W'(r_hund3);
            n_code[2] = CODE_W'(n_tens);
            n_code[3] = CODE_W'(n_ones);
        end else begin
            n_code = r_code3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_op1    <= i_req.opcode;
            r_code1  <= i_req.code;
            r_colon1 <= n_colon;
            r_value1 <= n_value;
        end
        r_op2    <= r_op1;
        r_code2  <= r_code1;
        r_colon2 <= r_colon1;
        r_thou2  <= n_thou;
        r_rem2   <= n_rem1;
        r_op3    <= r_op2;
        r_code3  <= r_code2;
        r_colon3 <= r_colon2;
        r_thou3  <= r_thou2;
        r_hund3  <= n_hund;
        r_rem3   <= n_rem2;
        r_code4  <= n_code;
        r_colon4 <= r_colon3;
    end

    assign o_codes.valid = r_v4;
    assign o_codes.code  = r_code4;
    assign o_codes.colon = r_colon4;

endmodule

`default_nettype wire

// ===== hdl/ssd_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssd_lane (
    input  logic [ssd_pkg::CODE_W-1:0] i_code,
    input  logic                       i_dot,
    output logic [7:0]                 o_pattern
);
    import ssd_pkg::*;

    logic [7:0] w_glyph;

    always_comb begin
        if (i_code < CODE_W'(GLYPH_COUNT)) begin
            w_glyph = GLYPH_TABLE[i_code];
        end else begin
            w_glyph = BLANK_PATTERN;
        end
        o_pattern = {w_glyph[7] | i_dot, w_glyph[6:0]};
    end

endmodule

`default_nettype wire

// ===== hdl/ssd_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssd_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  ssd_pkg::t_pattern_set i_pats,
    input  logic [2:0]            i_brightness,
    input  logic                  i_display_enable,
    output ssd_pkg::t_word        o_word
);
    import ssd_pkg::*;

    t_pattern_set     r_pat;
    logic [IDX_W-1:0] r_cnt;
    logic             r_run;
    t_word            r_word;

    logic [IDX_W-1:0] n_cnt;
    logic             n_run;
    logic [IDX_W-1:0] w_sel;
    t_word            n_word;

    always_comb begin
        n_cnt = r_cnt;
        n_run = r_run;
        w_sel = r_cnt;
        priority if (i_valid) begin
            w_sel = IDX_DATA_CMD;
            n_cnt = IDX_ADDR_CMD;
            n_run = 1'b1;
        end else if (r_run) begin
            n_cnt = r_cnt + IDX_W'(1);
            n_run = (r_cnt != IDX_CONTROL);
        end else begin
            n_run = 1'b0;
        end
    end

    always_comb begin
        n_word.strobe        = i_valid || r_run;
        n_word.bus_byte      = BLANK_PATTERN;
        n_word.start_before  = 1'b0;
        n_word.stop_after    = 1'b0;
        n_word.last_of_frame = 1'b0;
        unique case (w_sel)
            IDX_DATA_CMD: begin
                n_word.bus_byte     = DATA_CMD;
                n_word.start_before = 1'b1;
                n_word.stop_after   = 1'b1;
            end
            IDX_ADDR_CMD: begin
                n_word.bus_byte     = ADDR_CMD;
                n_word.start_before = 1'b1;
            end
            IDX_DIGIT0: n_word.bus_byte = r_pat[0];
            IDX_DIGIT1: n_word.bus_byte = r_pat[1];
            IDX_DIGIT2: n_word.bus_byte = r_pat[2];
            IDX_DIGIT3: begin
                n_word.bus_byte   = r_pat[3];
                n_word.stop_after = 1'b1;
            end
            IDX_CONTROL: begin
                n_word.bus_byte      = CTRL_BASE | {4'b0000, i_display_enable, i_brightness};
                n_word.start_before  = 1'b1;
                n_word.stop_after    = 1'b1;
                n_word.last_of_frame = 1'b1;
            end
            default: begin
                n_word.strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= IDX_DATA_CMD;
            r_word <= '0;
        end else begin
            r_run  <= n_run;
            r_cnt  <= n_cnt;
            r_word <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_pat <= i_pats;
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

// ===== hdl/ssd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "seven_segment_frame_sender_defines.svh"

module ssd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic [7:0] o_bus_byte,
    input logic       o_start_before,
    input logic       o_stop_after,
    input logic       o_last_of_frame
);
    import ssd_pkg::*;

    logic w_accept;
    logic w_data_word;
    logic w_addr_word;

    assign w_accept    = start && !busy;
    assign w_data_word = o_strobe && (o_bus_byte == DATA_CMD) && o_start_before &&
                         o_stop_after;
    assign w_addr_word = o_strobe && (o_bus_byte == ADDR_CMD) && o_start_before;

    `SSD_ASSERT_NEXT(a_busy_after_accept, w_accept, busy, "busy not raised after accept")

    `SSD_ASSERT(a_frame_begins, w_accept |-> ##5 w_data_word, "frame did not begin on time")

    `SSD_ASSERT_NEXT(a_addr_follows, w_data_word && !o_last_of_frame, w_addr_word, "address command missing")

    `SSD_ASSERT(a_last_closes_frame, (o_strobe && o_last_of_frame) |-> $past(w_data_word, 6), "last word late")

endmodule

bind seven_segment_frame_sender ssd_checker u_checker (.*);

`default_nettype wire
